[rtl/flsn_pkg.sv]
package flsn_pkg;

   typedef struct packed {
      logic signed [23:0] dx;
      logic signed [23:0] dy;
   } req_type;

   typedef struct packed {
      logic        [24:0] sigma_norm;
      logic signed [31:0] phi_alpha;
   } rsp_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 25;

   localparam logic [CSR_INDEX_W-1:0] CSR_NORM_EPS      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUMP_KNEE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_A        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_B        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_C      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_SIGMA   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPACING_SIGMA = 3'd6;

   typedef enum logic [1:0] {
      RHO_ZERO,
      RHO_ONE,
      RHO_FALL
   } rho_class_type;

   // Odd polynomial for the raised-cosine falloff, Q2.30.
   localparam logic [31:0] POLY_C9 = 32'd172272;
   localparam logic [31:0] POLY_COEF [4] = '{32'd5026995, 32'd85569306,
                                             32'd693598668, 32'd1686629713};

   localparam logic [30:0] Q30      = 31'h4000_0000;
   localparam logic [30:0] Q30_HALF = 31'h2000_0000;

endpackage

[rtl/flsn_isqrt.sv]
module flsn_isqrt #(
   parameter int IW = 50,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [IW-1:0] radicand,
   input  logic [SW-1:0] side_in,
   output logic          out_valid,
   output logic [IW/2-1:0] root,
   output logic [SW-1:0] side_out
);

   localparam int RW = IW / 2;

   logic          vld_ff  [RW+1];
   logic [RW+1:0] rem_ff  [RW+1];
   logic [RW-1:0] root_ff [RW+1];
   logic [IW-1:0] rest_ff [RW+1];
   logic [SW-1:0] side_ff [RW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         rest_ff[0] <= radicand;
         side_ff[0] <= side_in;
      end
   end

   // One result bit per stage: bring down two radicand bits, try 4y+1.
   for (genvar k = 1; k <= RW; k++) begin : g_step
      logic [RW+3:0] cur;
      logic [RW+3:0] trial;
      logic          take;

      assign cur   = {rem_ff[k-1], rest_ff[k-1][IW-1:IW-2]};
      assign trial = {2'b00, root_ff[k-1], 2'b01};
      assign take  = cur >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? (RW+2)'(cur - trial) : (RW+2)'(cur);
            root_ff[k] <= {root_ff[k-1][RW-2:0], take};
            rest_ff[k] <= {rest_ff[k-1][IW-3:0], 2'b00};
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[RW];
   assign root      = root_ff[RW];
   assign side_out  = side_ff[RW];

endmodule

[rtl/flsn_div.sv]
module flsn_div #(
   parameter int NW = 48,
   parameter int DW = 26,
   parameter int QW = 25,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] side_in,
   output logic          out_valid,
   output logic [QW-1:0] quo,
   output logic          ovf,
   output logic [SW-1:0] side_out
);

   localparam int HW = NW - QW;
   localparam int CW = (HW > DW) ? HW : DW;

   logic          vld_ff  [QW+1];
   logic [DW-1:0] rem_ff  [QW+1];
   logic [QW-1:0] bits_ff [QW+1];
   logic [DW-1:0] den_ff  [QW+1];
   logic          ovf_ff  [QW+1];
   logic [SW-1:0] side_ff [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   // The quotient fits QW bits exactly when the upper part of the
   // numerator is below the divisor; that part is then the first remainder.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= DW'(num[NW-1:QW]);
         bits_ff[0] <= num[QW-1:0];
         den_ff[0]  <= den;
         ovf_ff[0]  <= CW'(num[NW-1:QW]) >= CW'(den);
         side_ff[0] <= side_in;
      end
   end

   // The low numerator bits shift out at the top while quotient bits
   // shift in at the bottom of the same register.
   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [DW:0] trial;
      logic        take;

      assign trial = {rem_ff[k-1], bits_ff[k-1][QW-1]};
      assign take  = trial >= {1'b0, den_ff[k-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? DW'(trial - {1'b0, den_ff[k-1]}) : trial[DW-1:0];
            bits_ff[k] <= {bits_ff[k-1][QW-2:0], take};
            den_ff[k]  <= den_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign quo       = bits_ff[QW];
   assign ovf       = ovf_ff[QW];
   assign side_out  = side_ff[QW];

endmodule

[rtl/flocking_sigma_norm_phi_alpha.sv]
// Flocking interaction for one neighbor pair per word.
// The req channel carries a relative position (dx, dy) in signed Q7.16; the
// rsp channel returns its sigma norm and the interaction phi_alpha, which is
// the bump function of the norm over the range times the action function of
// the norm minus the spacing. Both channels use valid and ready.
// The csr port writes the seven coefficients by index; the user must let
// writes go in only while the pipeline is empty, as the block itself does
// not enforce it, and indexes beyond the list are dropped. The pipeline is
// made of the two digit-serial square roots, four restoring dividers with
// one quotient bit per stage, and fifteen arithmetic stages around them;
// the first root and the bump quotient change length with FRAC_BITS.
// Throughput is one word per cycle: a new word is taken in every cycle in
// which the output register is empty or is being read.
// When rsp_ready is low with a result waiting, the whole pipeline holds and
// req_ready drops in the same cycle, so nothing is lost or repeated.
// Reset empties the pipeline and loads the default coefficients.
module flocking_sigma_norm_phi_alpha #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  flsn_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output flsn_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_write_en,
   input  logic [flsn_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [flsn_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int F      = FRAC_BITS;
   localparam int SQ_W   = 47;
   localparam int Q_W    = 48;
   localparam int QE_W   = Q_W + 16;
   localparam int W1_RAW = (((QE_W - F) > (2 * F)) ? (QE_W - F) : (2 * F)) + 1;
   localparam int W1     = W1_RAW + (W1_RAW % 2);
   localparam int R1     = W1 / 2;
   localparam int S_W    = 25;
   localparam int X_W    = 27;
   localparam int UX_W   = 26;
   localparam int W2     = 54;
   localparam int R2     = W2 / 2;
   localparam int V_W    = 31;
   localparam int U_W    = ((F > 16) ? F : 16) + 1;
   localparam int FD_W   = F + 1;
   localparam int PV_W   = 58;
   localparam int PM_W   = 26;

   localparam logic [W1-1:0]   ONE2_1 = W1'(1) << (2 * F);
   localparam logic [W2-1:0]   ONE2_2 = W2'(1) << (2 * F);
   localparam logic [R1:0]     ONE_R1 = (R1 + 1)'(1) << F;
   localparam logic [U_W-1:0]  ONE_U  = U_W'(1) << F;
   localparam logic [FD_W-1:0] ONE_FD = FD_W'(1) << F;

   typedef struct packed {
      logic [S_W-1:0]  s;
      logic [UX_W-1:0] ux;
      logic            xneg;
   } root_side_type;

   typedef struct packed {
      logic [S_W-1:0] s;
      logic           xneg;
   } sig_side_type;

   typedef struct packed {
      logic [S_W-1:0] s;
      logic [V_W-1:0] sig;
      logic           xneg;
   } bump_side_type;

   typedef struct packed {
      logic [S_W-1:0]          s;
      logic [V_W-1:0]          sig;
      logic                    xneg;
      flsn_pkg::rho_class_type cls;
      logic                    fneg;
   } fall_side_type;

   // Coefficients.
   logic        [15:0] eps_ff;
   logic        [15:0] knee_ff;
   logic        [23:0] gain_a_ff;
   logic        [23:0] gain_b_ff;
   logic signed [23:0] offset_c_ff;
   logic        [24:0] range_ff;
   logic        [24:0] spacing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff      <= 16'd6554;
         knee_ff     <= 16'd13107;
         gain_a_ff   <= 24'd327680;
         gain_b_ff   <= 24'd327680;
         offset_c_ff <= 24'sd0;
         range_ff    <= 25'd65536;
         spacing_ff  <= 25'd52429;
      end else if (csr_write_en) begin
         unique case (csr_index)
            flsn_pkg::CSR_NORM_EPS:      eps_ff      <= csr_wdata[15:0];
            flsn_pkg::CSR_BUMP_KNEE:     knee_ff     <= csr_wdata[15:0];
            flsn_pkg::CSR_GAIN_A:        gain_a_ff   <= csr_wdata[23:0];
            flsn_pkg::CSR_GAIN_B:        gain_b_ff   <= csr_wdata[23:0];
            flsn_pkg::CSR_OFFSET_C:      offset_c_ff <= $signed(csr_wdata[23:0]);
            flsn_pkg::CSR_RANGE_SIGMA:   range_ff    <= csr_wdata[24:0];
            flsn_pkg::CSR_SPACING_SIGMA: spacing_ff  <= csr_wdata[24:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves together; it holds only when a result sits in
   // the output register and the receiver is not taking it.
   logic en;
   logic out_vld_ff;
   assign en        = !out_vld_ff || rsp_ready;
   assign req_ready = en;

   // Stage A: squares of the magnitudes.
   logic [23:0]     ax_in, ay_in;
   logic [SQ_W-1:0] sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic            a_vld_ff;

   assign ax_in  = req_data.dx[23] ? (24'd0 - $unsigned(req_data.dx)) : $unsigned(req_data.dx);
   assign ay_in  = req_data.dy[23] ? (24'd0 - $unsigned(req_data.dy)) : $unsigned(req_data.dy);
   assign sqx_in = ax_in * ax_in;
   assign sqy_in = ay_in * ay_in;

   // Stage B: squared length q.
   logic [Q_W-1:0] q_in, q_ff;
   logic           b_vld_ff;
   assign q_in = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // Stage C: radicand one^2 + q*eps.
   logic [QE_W-1:0] qe_in;
   logic [W1-1:0]   w1_in, w1_ff;
   logic [Q_W-1:0]  c_q_ff;
   logic            c_vld_ff;
   assign qe_in = q_ff * eps_ff;
   assign w1_in = ONE2_1 + W1'(qe_in >> F);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         q_ff   <= q_in;
         w1_ff  <= w1_in;
         c_q_ff <= q_ff;
      end
   end

   // Sigma norm in rationalized form: s = q / (sqrt(radicand) + one).
   logic           r1_vld;
   logic [R1-1:0]  root1;
   logic [Q_W-1:0] r1_q;

   flsn_isqrt #(.IW(W1), .SW(Q_W)) u_root_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_vld_ff),
      .radicand  (w1_ff),
      .side_in   (c_q_ff),
      .out_valid (r1_vld),
      .root      (root1),
      .side_out  (r1_q)
   );

   logic           s_vld;
   logic [S_W-1:0] s_quo;
   logic           s_ovf;

   flsn_div #(.NW(Q_W), .DW(R1 + 1), .QW(S_W), .SW(1)) u_div_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r1_vld),
      .num       (r1_q),
      .den       ({1'b0, root1} + ONE_R1),
      .side_in   (1'b0),
      .out_valid (s_vld),
      .quo       (s_quo),
      .ovf       (s_ovf),
      .side_out  ()
   );

   // Stage D: saturate the norm and form x = s - d + c.
   logic [S_W-1:0]        s_sat;
   logic signed [X_W-1:0] x_in;
   logic [UX_W-1:0]       ux_in;
   logic [S_W-1:0]        d_s_ff;
   logic [UX_W-1:0]       d_ux_ff;
   logic                  d_xneg_ff;
   logic                  d_vld_ff;

   assign s_sat = s_ovf ? {S_W{1'b1}} : s_quo;
   assign x_in  = $signed({2'b00, s_sat}) - $signed({2'b00, spacing_ff}) + X_W'(offset_c_ff);
   assign ux_in = x_in[X_W-1] ? UX_W'(-x_in) : UX_W'(x_in);

   // Stage E: radicand one^2 + x^2 of the action function.
   logic [W2-1:0] uxsq_in, w2_in, w2_ff;
   root_side_type e_side_ff;
   logic          e_vld_ff;

   assign uxsq_in = d_ux_ff * d_ux_ff;
   assign w2_in   = ONE2_2 + uxsq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= s_vld;
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_s_ff         <= s_sat;
         d_ux_ff        <= ux_in;
         d_xneg_ff      <= x_in[X_W-1];
         w2_ff          <= w2_in;
         e_side_ff.s    <= d_s_ff;
         e_side_ff.ux   <= d_ux_ff;
         e_side_ff.xneg <= d_xneg_ff;
      end
   end

   logic          r2_vld;
   logic [R2-1:0] root2;
   root_side_type r2_side;

   flsn_isqrt #(.IW(W2), .SW($bits(root_side_type))) u_root_act (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (e_vld_ff),
      .radicand  (w2_ff),
      .side_in   (e_side_ff),
      .out_valid (r2_vld),
      .root      (root2),
      .side_out  (r2_side)
   );

   // sigma1 magnitude: |x| * 2^30 / sqrt(one^2 + x^2), at most 2^30.
   sig_side_type   sg_side_in, sg_side;
   logic           sg_vld;
   logic [V_W-1:0] sig;

   assign sg_side_in.s    = r2_side.s;
   assign sg_side_in.xneg = r2_side.xneg;

   flsn_div #(.NW(UX_W + 30), .DW(R2), .QW(V_W), .SW($bits(sig_side_type))) u_div_sig (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r2_vld),
      .num       ({r2_side.ux, 30'd0}),
      .den       (root2),
      .side_in   (sg_side_in),
      .out_valid (sg_vld),
      .quo       (sig),
      .ovf       (),
      .side_out  (sg_side)
   );

   // Bump argument u = s * one / r; an overflow means u is above both one
   // and the knee.
   bump_side_type  bu_side_in, bu_side;
   logic           u_vld;
   logic [U_W-1:0] u_quo;
   logic           u_ovf;

   assign bu_side_in.s    = sg_side.s;
   assign bu_side_in.sig  = sig;
   assign bu_side_in.xneg = sg_side.xneg;

   flsn_div #(.NW(S_W + F), .DW(25), .QW(U_W), .SW($bits(bump_side_type))) u_div_bump (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sg_vld),
      .num       ({sg_side.s, {F{1'b0}}}),
      .den       (range_ff),
      .side_in   (bu_side_in),
      .out_valid (u_vld),
      .quo       (u_quo),
      .ovf       (u_ovf),
      .side_out  (bu_side)
   );

   // Stage G: classify the bump region and set up the falloff argument
   // v = (2(u-h) - (one-h)) / (one-h), kept as a magnitude and a sign.
   flsn_pkg::rho_class_type cls_in;
   logic [U_W-1:0]          knee_u;
   logic [FD_W:0]           tdiff_in;
   logic [FD_W-1:0]         denf_in, mag_in;
   logic                    fneg_in;
   fall_side_type           g_side_ff;
   logic [FD_W-1:0]         g_mag_ff, g_denf_ff;
   logic                    g_vld_ff;

   assign knee_u   = U_W'(knee_ff);
   assign tdiff_in = {FD_W'(u_quo - knee_u), 1'b0};
   assign denf_in  = ONE_FD - FD_W'(knee_ff);
   assign fneg_in  = tdiff_in < {1'b0, denf_in};
   assign mag_in   = fneg_in ? FD_W'({1'b0, denf_in} - tdiff_in)
                             : FD_W'(tdiff_in - {1'b0, denf_in});

   always_comb begin
      priority if (range_ff == 25'd0) begin
         cls_in = flsn_pkg::RHO_ZERO;
      end else if (u_ovf) begin
         cls_in = flsn_pkg::RHO_ZERO;
      end else if (u_quo < knee_u) begin
         cls_in = flsn_pkg::RHO_ONE;
      end else if (u_quo > ONE_U) begin
         cls_in = flsn_pkg::RHO_ZERO;
      end else if (knee_u >= ONE_U) begin
         cls_in = flsn_pkg::RHO_ONE;
      end else begin
         cls_in = flsn_pkg::RHO_FALL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (en) begin
         g_vld_ff <= u_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_side_ff.s    <= bu_side.s;
         g_side_ff.sig  <= bu_side.sig;
         g_side_ff.xneg <= bu_side.xneg;
         g_side_ff.cls  <= cls_in;
         g_side_ff.fneg <= fneg_in;
         g_mag_ff       <= mag_in;
         g_denf_ff      <= denf_in;
      end
   end

   fall_side_type  fa_side;
   logic           v_vld;
   logic [V_W-1:0] v_quo;

   flsn_div #(.NW(FD_W + 30), .DW(FD_W), .QW(V_W), .SW($bits(fall_side_type))) u_div_fall (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_vld_ff),
      .num       ({g_mag_ff, 30'd0}),
      .den       (g_denf_ff),
      .side_in   (g_side_ff),
      .out_valid (v_vld),
      .quo       (v_quo),
      .ovf       (),
      .side_out  (fa_side)
   );

   // Polynomial stages: the first squares v, the next four run the Horner
   // steps, each with one truncated Q2.30 product.
   logic           py_vld_ff  [5];
   fall_side_type  py_side_ff [5];
   logic [V_W-1:0] py_v_ff    [5];
   logic [V_W-1:0] py_v2_ff   [5];
   logic [31:0]    py_p_ff    [5];

   logic [V_W-1:0]   vc_in;
   logic [2*V_W-1:0] vsq_in;
   assign vc_in  = (v_quo > flsn_pkg::Q30) ? flsn_pkg::Q30 : v_quo;
   assign vsq_in = vc_in * vc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         py_vld_ff[0] <= 1'b0;
      end else if (en) begin
         py_vld_ff[0] <= v_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         py_side_ff[0] <= fa_side;
         py_v_ff[0]    <= vc_in;
         py_v2_ff[0]   <= V_W'(vsq_in >> 30);
         py_p_ff[0]    <= flsn_pkg::POLY_C9;
      end
   end

   for (genvar k = 1; k < 5; k++) begin : g_poly
      logic [31+V_W:0] prod;
      assign prod = py_p_ff[k-1] * py_v2_ff[k-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            py_vld_ff[k] <= 1'b0;
         end else if (en) begin
            py_vld_ff[k] <= py_vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            py_side_ff[k] <= py_side_ff[k-1];
            py_v_ff[k]    <= py_v_ff[k-1];
            py_v2_ff[k]   <= py_v2_ff[k-1];
            py_p_ff[k]    <= flsn_pkg::POLY_COEF[k-1] - 32'(prod >> 30);
         end
      end
   end

   // Stage I: finish the sine-like term and pick rho in Q2.30.
   logic [31+V_W:0] snm_in;
   logic [32:0]     sn_in;
   logic [V_W-1:0]  snc_in, rho_fall_in, rho_in;
   logic [V_W-1:0]  i_rho_ff;
   logic [S_W-1:0]  i_s_ff;
   logic [V_W-1:0]  i_sig_ff;
   logic            i_xneg_ff;
   logic            i_vld_ff;

   assign snm_in      = py_p_ff[4] * py_v_ff[4];
   assign sn_in       = 33'(snm_in >> 30);
   assign snc_in      = (sn_in > {2'b00, flsn_pkg::Q30}) ? flsn_pkg::Q30 : V_W'(sn_in);
   assign rho_fall_in = py_side_ff[4].fneg ? (flsn_pkg::Q30_HALF + (snc_in >> 1))
                                           : (flsn_pkg::Q30_HALF - (snc_in >> 1));

   always_comb begin
      unique case (py_side_ff[4].cls)
         flsn_pkg::RHO_ZERO: rho_in = '0;
         flsn_pkg::RHO_ONE:  rho_in = flsn_pkg::Q30;
         flsn_pkg::RHO_FALL: rho_in = rho_fall_in;
         default:            rho_in = '0;
      endcase
   end

   // Stage J: P = (a+b)*sigma1 + (a-b)*2^30.
   logic [24:0]            apb_in;
   logic signed [24:0]     amb_in;
   logic [S_W+V_W-1:0]     pmag_in;
   logic signed [PV_W-1:0] pterm_in, pv_in;
   logic signed [PV_W-1:0] j_pv_ff;
   logic [V_W-1:0]         j_rho_ff;
   logic [S_W-1:0]         j_s_ff;
   logic                   j_vld_ff;

   assign apb_in   = {1'b0, gain_a_ff} + {1'b0, gain_b_ff};
   assign amb_in   = $signed({1'b0, gain_a_ff}) - $signed({1'b0, gain_b_ff});
   assign pmag_in  = apb_in * i_sig_ff;
   assign pterm_in = i_xneg_ff ? -$signed({2'b00, pmag_in}) : $signed({2'b00, pmag_in});
   assign pv_in    = pterm_in + (PV_W'(amb_in) <<< 30);

   // Stage K: phi magnitude truncated toward zero, times rho.
   logic [PV_W-1:0]      apv_in;
   logic [PM_W-1:0]      phim_in;
   logic [V_W+PM_W-1:0]  prod_in, k_prod_ff;
   logic                 k_neg_ff;
   logic [S_W-1:0]       k_s_ff;
   logic                 k_vld_ff;

   assign apv_in  = j_pv_ff[PV_W-1] ? PV_W'(-j_pv_ff) : $unsigned(j_pv_ff);
   assign phim_in = PM_W'(apv_in >> 31);
   assign prod_in = j_rho_ff * phim_in;

   // Output register.
   logic [26:0]       res_in;
   logic signed [31:0] phi_in;
   flsn_pkg::rsp_type rsp_ff;

   assign res_in = 27'(k_prod_ff >> 30);
   assign phi_in = k_neg_ff ? -$signed(32'(res_in)) : $signed(32'(res_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         i_vld_ff   <= 1'b0;
         j_vld_ff   <= 1'b0;
         k_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         i_vld_ff   <= py_vld_ff[4];
         j_vld_ff   <= i_vld_ff;
         k_vld_ff   <= j_vld_ff;
         out_vld_ff <= k_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         i_rho_ff           <= rho_in;
         i_s_ff             <= py_side_ff[4].s;
         i_sig_ff           <= py_side_ff[4].sig;
         i_xneg_ff          <= py_side_ff[4].xneg;
         j_pv_ff            <= pv_in;
         j_rho_ff           <= i_rho_ff;
         j_s_ff             <= i_s_ff;
         k_prod_ff          <= prod_in;
         k_neg_ff           <= j_pv_ff[PV_W-1];
         k_s_ff             <= j_s_ff;
         rsp_ff.sigma_norm  <= k_s_ff;
         rsp_ff.phi_alpha   <= phi_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sim/flocking_sigma_norm_phi_alpha_tb.sv]
`timescale 1ns / 100ps

module flocking_sigma_norm_phi_alpha_tb;

   localparam int RANDOM_WORDS  = 1200;
   localparam int CONFIG_PHASES = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam longint unsigned ONE = 64'd1 << 16;
   localparam longint unsigned Q30_L = 64'd1 << 30;
   // An index past the end of the register list.
   localparam logic [flsn_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   flsn_pkg::req_type                    req_data;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   flsn_pkg::rsp_type                    rsp_data;
   logic                                 csr_write_en;
   logic [flsn_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [flsn_pkg::CSR_DATA_W-1:0]      csr_wdata;

   flocking_sigma_norm_phi_alpha dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the coefficient registers, updated with every write.
   logic        [15:0] eps_q;
   logic        [15:0] knee_q;
   logic        [23:0] gain_a_q;
   logic        [23:0] gain_b_q;
   logic signed [23:0] offset_c_q;
   logic        [24:0] range_q;
   logic        [24:0] spacing_q;

   // A directed row: the section selects the coefficient set, and the
   // expected result is only typed in where it is obvious.
   typedef struct {
      int                 sect;
      logic signed [23:0] dx;
      logic signed [23:0] dy;
      bit                 known;
      logic        [24:0] norm;
      logic signed [31:0] phi;
   } stim_row_type;

   stim_row_type       stim_rows[$];
   flsn_pkg::rsp_type  pending_rsp[$];
   bit                 pending_known[$];
   int                 errors;
   int                 words_sent;
   int                 words_checked;
   int                 csr_writes;
   bit                 hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous watchdog: the slowest legal run is far below this.
   initial begin
      #5ms;
      $display("flocking_sigma_norm_phi_alpha_tb failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on result %0d: %s got %0d, expected %0d",
               words_checked, what, got, want);
      errors++;
   endtask

   // Floor square root, digit by digit.
   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Raised-cosine falloff in Q2.30 from the odd polynomial on |v|.
   function automatic longint unsigned bump_falloff(input longint num,
                                                     input longint unsigned den);
      longint unsigned mag;
      longint unsigned v;
      longint unsigned v2;
      longint unsigned p;
      longint unsigned sn;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      v = (mag << 30) / den;
      if (v > Q30_L) v = Q30_L;
      v2 = (v * v) >> 30;
      p = 64'd172272;
      p = 64'd5026995 - ((p * v2) >> 30);
      p = 64'd85569306 - ((p * v2) >> 30);
      p = 64'd693598668 - ((p * v2) >> 30);
      p = 64'd1686629713 - ((p * v2) >> 30);
      sn = (p * v) >> 30;
      if (sn > Q30_L) sn = Q30_L;
      return (num < 0) ? (Q30_L >> 1) + (sn >> 1) : (Q30_L >> 1) - (sn >> 1);
   endfunction

   // Sigma norm and interaction for one relative position.
   function automatic flsn_pkg::rsp_type flocking_interaction(input logic signed [23:0] dx,
                                                              input logic signed [23:0] dy);
      longint            sx;
      longint            sy;
      longint unsigned   ax;
      longint unsigned   ay;
      longint unsigned   q;
      longint unsigned   w;
      longint unsigned   s;
      longint unsigned   u;
      longint unsigned   rho;
      longint unsigned   ux;
      longint unsigned   sig;
      longint unsigned   phim;
      longint unsigned   res;
      longint            x;
      longint            pv;
      flsn_pkg::rsp_type r;
      sx = dx;
      sy = dy;
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      q = ax * ax + ay * ay;
      w = (ONE << 16) + ((q * longint'(eps_q)) >> 16);
      s = q / (floor_sqrt(w) + ONE);
      if (s > 64'h1FF_FFFF) s = 64'h1FF_FFFF;

      if (range_q == 0) begin
         rho = 0;
      end else begin
         u = (s << 16) / longint'(range_q);
         if (u < knee_q) rho = Q30_L;
         else if (u > ONE) rho = 0;
         else rho = bump_falloff(2 * (longint'(u) - longint'(knee_q))
                                 - (longint'(ONE) - longint'(knee_q)),
                                 ONE - knee_q);
      end

      // Action function: sigma1 of the shifted norm, then the gain blend.
      x = longint'(s) - longint'(spacing_q) + longint'(offset_c_q);
      ux = (x < 0) ? -x : x;
      sig = (ux << 30) / floor_sqrt((ONE << 16) + ux * ux);
      pv = longint'((longint'(gain_a_q) + longint'(gain_b_q)) * sig);
      if (x < 0) pv = -pv;
      pv += (longint'(gain_a_q) - longint'(gain_b_q)) * longint'(Q30_L);
      phim = ((pv < 0) ? longint'(-pv) : pv) >> 31;
      res = (rho * phim) >> 30;
      if (pv < 0) begin
         if (res > 64'h8000_0000) res = 64'h8000_0000;
         r.phi_alpha = 32'(-res);
      end else begin
         if (res > 64'h7FFF_FFFF) res = 64'h7FFF_FFFF;
         r.phi_alpha = 32'(res);
      end
      r.sigma_norm = 25'(s);
      return r;
   endfunction

   // Scoreboard: results are checked before new words are predicted.
   always @(posedge clock) begin
      flsn_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $display("result with no word outstanding");
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               void'(pending_known.pop_front());
               if (rsp_data.sigma_norm !== want.sigma_norm)
                  report_mismatch("sigma_norm", longint'(rsp_data.sigma_norm),
                                  longint'(want.sigma_norm));
               if (rsp_data.phi_alpha !== want.phi_alpha)
                  report_mismatch("phi_alpha", longint'(rsp_data.phi_alpha),
                                  longint'(want.phi_alpha));
            end
            words_checked++;
         end
         if (req_valid && req_ready) begin
            pending_rsp.push_back(flocking_interaction(req_data.dx, req_data.dy));
            pending_known.push_back(1'b0);
         end
      end
   end

   // Mostly short gaps, occasionally a long one.
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return 0;
      if (pick < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Receiver: random stalls, plus one long hold-off on request so that the
   // pipeline fills and req_ready has to drop.
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            n = gap_len();
            if (n != 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(12, 1)) @(posedge clock);
         end
      end
   end

   // One register write per clock; the shadow copy follows the same masking.
   task automatic write_csr(input logic [flsn_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [24:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         flsn_pkg::CSR_NORM_EPS:      eps_q      = value[15:0];
         flsn_pkg::CSR_BUMP_KNEE:     knee_q     = value[15:0];
         flsn_pkg::CSR_GAIN_A:        gain_a_q   = value[23:0];
         flsn_pkg::CSR_GAIN_B:        gain_b_q   = value[23:0];
         flsn_pkg::CSR_OFFSET_C:      offset_c_q = value[23:0];
         flsn_pkg::CSR_RANGE_SIGMA:   range_q    = value;
         flsn_pkg::CSR_SPACING_SIGMA: spacing_q  = value;
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   // Writes go in only once every outstanding result has been read back.
   task automatic load_coefficients(input logic [15:0] eps, input logic [15:0] knee,
                                    input logic [23:0] ga, input logic [23:0] gb,
                                    input logic [23:0] oc, input logic [24:0] rs,
                                    input logic [24:0] sp);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      write_csr(flsn_pkg::CSR_NORM_EPS, 25'(eps));
      write_csr(flsn_pkg::CSR_BUMP_KNEE, 25'(knee));
      write_csr(flsn_pkg::CSR_GAIN_A, 25'(ga));
      write_csr(flsn_pkg::CSR_GAIN_B, 25'(gb));
      write_csr(flsn_pkg::CSR_OFFSET_C, 25'(oc));
      write_csr(flsn_pkg::CSR_RANGE_SIGMA, rs);
      write_csr(flsn_pkg::CSR_SPACING_SIGMA, sp);
      // An index past the list must leave every coefficient alone.
      write_csr(CSR_UNUSED, 25'h1FF_FFFF);
      csr_write_en <= 1'b0;
   endtask

   // Offer one word; valid stays up across back-to-back words.
   task automatic send_word(input logic signed [23:0] dx, input logic signed [23:0] dy,
                            input int gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_data.dx <= dx;
      req_data.dy <= dy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   function automatic logic signed [23:0] random_coord();
      int pick;
      pick = $urandom_range(3);
      // Small vectors land around the range and spacing, where rho falls off.
      if (pick < 2) return 24'($signed($urandom_range(262143)) - 131072);
      if (pick == 2) return 24'($signed($urandom_range(2097151)) - 1048576);
      return 24'($urandom);
   endfunction

   task automatic add_row(input int sect, input int dx, input int dy, input bit known,
                          input int norm, input int phi);
      stim_row_type r;
      r.sect = sect;
      r.dx = 24'(dx);
      r.dy = 24'(dy);
      r.known = known;
      r.norm = 25'(norm);
      r.phi = phi;
      stim_rows.push_back(r);
   endtask

   task automatic select_section(input int sect);
      case (sect)
         0: load_coefficients(16'd6554, 16'd13107, 24'd327680, 24'd327680,
                              24'd0, 25'd65536, 25'd52429);
         // Zero epsilon gives half the squared length; zero range kills rho.
         1: load_coefficients(16'd0, 16'd13107, 24'd327680, 24'd327680,
                              24'd0, 25'd0, 25'd52429);
         2: load_coefficients(16'hFFFF, 16'd0, 24'hFF_FFFF, 24'd0,
                              24'h7F_FFFF, 25'h1FF_FFFF, 25'd0);
         default: load_coefficients(16'd1, 16'hFFFF, 24'd0, 24'hFF_FFFF,
                                    24'h80_0000, 25'd1, 25'h1FF_FFFF);
      endcase
   endtask

   initial begin
      int                cur_sect;
      int                gap;
      int                burst;
      stim_row_type      r;
      flsn_pkg::rsp_type want;
      errors = 0;
      words_sent = 0;
      words_checked = 0;
      csr_writes = 0;
      hold_request = 1'b0;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      eps_q = 16'd6554;
      knee_q = 16'd13107;
      gain_a_q = 24'd327680;
      gain_b_q = 24'd327680;
      offset_c_q = 24'sd0;
      range_q = 25'd65536;
      spacing_q = 25'd52429;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Section 0 runs on the reset coefficients.
      add_row(0, 0, 0, 1'b0, 0, 0);
      add_row(0, 8388607, 8388607, 1'b0, 0, 0);
      add_row(0, -8388608, -8388608, 1'b0, 0, 0);
      add_row(0, 65536, 0, 1'b0, 0, 0);
      add_row(0, 0, -98304, 1'b0, 0, 0);
      add_row(0, 150000, 150000, 1'b0, 0, 0);
      add_row(1, 0, 0, 1'b1, 0, 0);
      add_row(1, -8388608, -8388608, 1'b1, 33554431, 0);
      add_row(1, 8388607, 0, 1'b1, 33554431, 0);
      add_row(1, 1024, -1024, 1'b1, 16, 0);
      add_row(2, 0, 0, 1'b0, 0, 0);
      add_row(2, 8388607, -8388608, 1'b0, 0, 0);
      add_row(2, 70000, 0, 1'b0, 0, 0);
      add_row(2, -300000, 20000, 1'b0, 0, 0);
      add_row(3, 0, 0, 1'b0, 0, 0);
      add_row(3, 1, 1, 1'b0, 0, 0);
      add_row(3, 300, -300, 1'b0, 0, 0);
      add_row(3, -8388608, 8388607, 1'b0, 0, 0);
      add_row(0, 40000, 40000, 1'b0, 0, 0);

      cur_sect = -1;
      foreach (stim_rows[i]) begin
         r = stim_rows[i];
         if (r.sect != cur_sect) begin
            select_section(r.sect);
            cur_sect = r.sect;
         end
         send_word(r.dx, r.dy, gap_len());
         // Where the answer is obvious, hold the predictor to it as well.
         if (r.known) begin
            want = flocking_interaction(r.dx, r.dy);
            if (want.sigma_norm !== r.norm)
               report_mismatch("typed sigma_norm", longint'(want.sigma_norm),
                               longint'(r.norm));
            if (want.phi_alpha !== r.phi)
               report_mismatch("typed phi_alpha", longint'(want.phi_alpha),
                               longint'(r.phi));
         end
      end

      // Random part in phases, each with a fresh coefficient set.
      for (int ph = 0; ph < CONFIG_PHASES; ph++) begin
         if (ph == 0) begin
            select_section(0);
         end else begin
            load_coefficients(16'($urandom_range(65535, 1)), 16'($urandom),
                              24'($urandom_range(1048575)), 24'($urandom_range(1048575)),
                              24'($signed($urandom_range(262143)) - 131072),
                              25'($urandom_range(200000, 1)), 25'($urandom_range(150000)));
         end
         // Keep some phases free of sender gaps.
         burst = (ph % 3 == 1) ? 1 : 0;
         for (int k = 0; k < RANDOM_WORDS / CONFIG_PHASES; k++) begin
            if (ph == 2 && k == 10) hold_request = 1'b1;
            gap = (burst != 0) ? 0 : gap_len();
            send_word(random_coord(), random_coord(), gap);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("covered %0d words over %0d coefficient writes, %0d results checked",
               words_sent, csr_writes, words_checked);
      $display("including zero epsilon, zero range, extreme gains, a long output stall");
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("flocking_sigma_norm_phi_alpha_tb passed");
      end else begin
         $display("flocking_sigma_norm_phi_alpha_tb failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/flsn_pkg.sv
rtl/flsn_isqrt.sv
rtl/flsn_div.sv
rtl/flocking_sigma_norm_phi_alpha.sv
sim/flocking_sigma_norm_phi_alpha_tb.sv
